// ----- hw/rtl/far_pkg.sv -----
// Shared types and constants for the fraction add and reduce block.
package far_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int RAW_NUM_W = 2 * IN_WIDTH + 1;
    localparam int RAW_DEN_W = 2 * IN_WIDTH;
    localparam int MAG_W     = 2 * IN_WIDTH;
    localparam int CNT_W     = $clog2(MAG_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_AD,
        S_MUL_CB,
        S_MUL_BD,
        S_EUC_INIT,
        S_DIV,
        S_DIV_END,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DK_REM,
        DK_QNUM,
        DK_QDEN
    } t_div_kind;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
        t_div_kind        kind;
    } t_div_cmd;

endpackage

// ----- hw/rtl/fraction_add_reduce.sv -----
// Adds two signed fractions and reduces the sum by Euclid's method.
// Sequence: multiplies a*d, c*b and b*d in turn, a set-up step, then (k + 2) restoring
// divisions (k = Euclid remainder steps), then the output register; a zero input denominator
// skips the multiplies and divisions and goes straight to the done state.
// Throughput: one transaction at a time; the shared restoring divider sets the rate.
// Reset: synchronous, active low; clears the sequencer and the output valid flag.
module fraction_add_reduce (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [far_pkg::IN_WIDTH-1:0]   i_num_a,
    input  logic signed [far_pkg::IN_WIDTH-1:0]   i_den_a,
    input  logic signed [far_pkg::IN_WIDTH-1:0]   i_num_b,
    input  logic signed [far_pkg::IN_WIDTH-1:0]   i_den_b,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [far_pkg::RAW_NUM_W-1:0]  o_raw_num,
    output logic signed [far_pkg::RAW_DEN_W-1:0]  o_raw_den,
    output logic signed [far_pkg::RAW_NUM_W-1:0]  o_red_num,
    output logic signed [far_pkg::RAW_DEN_W-1:0]  o_red_den,
    output logic                                  o_status
);

    localparam int W  = far_pkg::IN_WIDTH;
    localparam int NW = far_pkg::RAW_NUM_W;
    localparam int DW = far_pkg::RAW_DEN_W;
    localparam int MW = far_pkg::MAG_W;
    localparam int CW = far_pkg::CNT_W;

    far_pkg::t_state    r_state, n_state;
    far_pkg::t_div_kind r_kind;
    far_pkg::t_div_cmd  div_cmd;

    logic signed [W-1:0]  r_a, r_b, r_c, r_d;
    logic signed [NW-1:0] r_rn, r_red_num;
    logic signed [DW-1:0] r_rd, r_red_den;
    logic                 r_status;
    logic [MW-1:0]        r_y;
    logic                 r_sy, r_sx;
    logic [MW-1:0]        r_div_q, r_div_r, r_div_d;
    logic [CW-1:0]        r_cnt;

    logic                 r_out_valid, r_out_status;
    logic signed [NW-1:0] r_out_raw_num, r_out_red_num;
    logic signed [DW-1:0] r_out_raw_den, r_out_red_den;

    logic                 in_acc, out_free, den_zero;
    logic signed [W-1:0]  mul_x, mul_y;
    logic signed [DW-1:0] prod;
    logic [MW-1:0]        rn_mag, rd_mag;
    logic                 rn_neg, rd_neg;
    logic [MW:0]          rem_sh, rem_diff;
    logic                 q_bit;
    logic [NW-1:0]        qn_ext;

    assign o_ready  = (r_state == far_pkg::S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign den_zero = (i_den_a == '0) || (i_den_b == '0);

    assign rn_neg = r_rn[NW-1];
    assign rd_neg = r_rd[DW-1];
    assign rn_mag = rn_neg ? MW'(-r_rn) : MW'(r_rn);
    assign rd_mag = rd_neg ? MW'(-r_rd) : MW'(r_rd);

    // shared signed multiplier
    always_comb begin
        unique case (r_state)
            far_pkg::S_MUL_CB: begin
                mul_x = r_c;
                mul_y = r_b;
            end
            far_pkg::S_MUL_BD: begin
                mul_x = r_b;
                mul_y = r_d;
            end
            default: begin
                mul_x = r_a;
                mul_y = r_d;
            end
        endcase
    end
    assign prod = DW'(mul_x * mul_y);

    // shared restoring divider step
    assign rem_sh   = {r_div_r, r_div_q[MW-1]};
    assign rem_diff = rem_sh - {1'b0, r_div_d};
    assign q_bit    = !rem_diff[MW];
    assign qn_ext   = NW'(r_div_q);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            far_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = den_zero ? far_pkg::S_DONE : far_pkg::S_MUL_AD;
                end
            end
            far_pkg::S_MUL_AD:   n_state = far_pkg::S_MUL_CB;
            far_pkg::S_MUL_CB:   n_state = far_pkg::S_MUL_BD;
            far_pkg::S_MUL_BD:   n_state = far_pkg::S_EUC_INIT;
            far_pkg::S_EUC_INIT: begin
                n_state = (r_rd == '0) ? far_pkg::S_DONE : far_pkg::S_DIV;
            end
            far_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = far_pkg::S_DIV_END;
                end
            end
            far_pkg::S_DIV_END: begin
                n_state = (r_kind == far_pkg::DK_QDEN) ? far_pkg::S_DONE : far_pkg::S_DIV;
            end
            far_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = far_pkg::S_IDLE;
                end
            end
            default: n_state = far_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        div_cmd = '{start: 1'b0, dividend: rn_mag, divisor: rd_mag, kind: far_pkg::DK_REM};
        unique case (r_state)
            far_pkg::S_EUC_INIT: begin
                div_cmd.start = (r_rd != '0);
            end
            far_pkg::S_DIV_END: begin
                unique case (r_kind)
                    far_pkg::DK_REM: begin
                        div_cmd.start = 1'b1;
                        if (r_div_r == '0) begin
                            div_cmd.divisor = r_y;
                            div_cmd.kind    = far_pkg::DK_QNUM;
                        end else begin
                            div_cmd.dividend = r_y;
                            div_cmd.divisor  = r_div_r;
                        end
                    end
                    far_pkg::DK_QNUM: begin
                        div_cmd.start    = 1'b1;
                        div_cmd.dividend = rd_mag;
                        div_cmd.divisor  = r_y;
                        div_cmd.kind     = far_pkg::DK_QDEN;
                    end
                    default: div_cmd.start = 1'b0;
                endcase
            end
            default: div_cmd.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= far_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            far_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_a       <= i_num_a;
                    r_b       <= i_den_a;
                    r_c       <= i_num_b;
                    r_d       <= i_den_b;
                    r_status  <= den_zero;
                    r_rn      <= '0;
                    r_rd      <= '0;
                    r_red_num <= '0;
                    r_red_den <= '0;
                end
            end
            far_pkg::S_MUL_AD: r_rn <= NW'(prod);
            far_pkg::S_MUL_CB: r_rn <= r_rn + NW'(prod);
            far_pkg::S_MUL_BD: r_rd <= prod;
            far_pkg::S_EUC_INIT: begin
                r_y  <= rd_mag;
                r_sy <= rd_neg;
                r_sx <= rn_neg;
                if (r_rd == '0) begin
                    r_status <= 1'b1;
                end
            end
            far_pkg::S_DIV: begin
                r_div_q <= {r_div_q[MW-2:0], q_bit};
                r_div_r <= q_bit ? rem_diff[MW-1:0] : rem_sh[MW-1:0];
                r_cnt   <= r_cnt - 1'b1;
            end
            far_pkg::S_DIV_END: begin
                unique case (r_kind)
                    far_pkg::DK_REM: begin
                        if (r_div_r != '0) begin
                            r_y  <= r_div_r;
                            r_sy <= r_sx;
                            r_sx <= r_sy;
                        end
                    end
                    far_pkg::DK_QNUM: begin
                        r_red_num <= (rn_neg != r_sy) ? -$signed(qn_ext) : $signed(qn_ext);
                    end
                    default: begin
                        r_red_den <= (rd_neg != r_sy) ? -$signed(DW'(r_div_q))
                                                      : $signed(DW'(r_div_q));
                    end
                endcase
            end
            default: ;
        endcase
        if (div_cmd.start) begin
            r_div_q <= div_cmd.dividend;
            r_div_d <= div_cmd.divisor;
            r_div_r <= '0;
            r_cnt   <= CW'(MW - 1);
            r_kind  <= div_cmd.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == far_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == far_pkg::S_DONE && out_free) begin
            r_out_raw_num <= r_rn;
            r_out_raw_den <= r_rd;
            r_out_red_num <= r_red_num;
            r_out_red_den <= r_red_den;
            r_out_status  <= r_status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_raw_num = r_out_raw_num;
    assign o_raw_den = r_out_raw_den;
    assign o_red_num = r_out_red_num;
    assign o_red_den = r_out_red_den;
    assign o_status  = r_out_status;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == far_pkg::S_DIV |-> r_div_d != '0)
        else $error("divider running with zero divisor");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_red_num == '0 && o_red_den == '0 && o_raw_den == '0)
        else $error("status set with nonzero result");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> o_red_den != '0 && o_raw_den != '0)
        else $error("zero denominator on good result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready held after accepting a transaction");

endmodule
